[rtl/cr1_pkg.sv]
`default_nettype none

package cr1_pkg;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_CLOCK = 2'd1,
      CMD_LOOK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOCK,
      ST_LOOK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;       // request accepted this cycle
      logic       load_key;      // fill the live halves from the key
      logic       start_look;    // copy live halves into the scratch LFSR
      logic       step_live;     // step the live LFSR with the next input bit
      logic       step_scratch;  // step the scratch LFSR with zero input
      logic       check_bit;     // this scratch step gives the parity bit of a byte
      logic [4:0] bit_idx;       // position of this step's keystream bit
      logic       emit;          // move the finished result into the output register
   } dp_cmd_type;

   localparam int HALF_W = 24;
   localparam int KEY_W  = 48;
   localparam int WORD_W = 32;
   localparam logic [5:0] MAX_BITS = 6'd32;
   localparam logic [3:0] PARITY_PHASE = 4'd8;

   localparam logic [HALF_W-1:0] TAPS_ODD  = 24'h29CE5C;
   localparam logic [HALF_W-1:0] TAPS_EVEN = 24'h870804;

   // Nonlinear filter tables: two 4-input layers and the 5-input output layer.
   localparam logic [15:0] FILT_A = 16'hF22C;
   localparam logic [15:0] FILT_B = 16'hD938;
   localparam logic [31:0] FILT_C = 32'hEC57E80A;

   // Keystream bit produced by the current odd half.
   function automatic logic ks_filter(input logic [HALF_W-1:0] x);
      logic [4:0] f;
      f = {FILT_A[x[3:0]], FILT_B[x[7:4]], FILT_A[x[11:8]], FILT_A[x[15:12]],
           FILT_B[x[19:16]]};
      return FILT_C[f];
   endfunction

   // Odd cells of the LFSR as loaded from the key (bytes are bit-reversed).
   function automatic logic [HALF_W-1:0] key_odd_half(input logic [KEY_W-1:0] key);
      logic [HALF_W-1:0] r;
      for (int m = 0; m < HALF_W; m++) begin
         r[m] = key[(2 * m) ^ 7];
      end
      return r;
   endfunction

   // Even cells of the LFSR as loaded from the key.
   function automatic logic [HALF_W-1:0] key_even_half(input logic [KEY_W-1:0] key);
      logic [HALF_W-1:0] r;
      for (int m = 0; m < HALF_W; m++) begin
         r[m] = key[(2 * m + 1) ^ 7];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/crypto1_keystream_cipher_core.sv]
`default_nettype none

// Crypto-1 keystream generator with a 48-bit LFSR held as odd and even halves.
// Requests are handled one at a time through a single LFSR step unit that does
// one step per clock: load and unused commands take no steps, clocking n bits
// (n saturated to 32) steps the live LFSR once per bit, and a parity lookahead
// steps the scratch LFSR over each byte's 8 bits and parity bit. The result
// sits in an output register, so the next request is accepted while it waits.
// The key is written through the APB port at byte address 0 and read back
// there; load copies it to the LFSR; lookahead never disturbs the live state.
module crypto1_keystream_cipher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[1:0], data_in[33:2], bit_count[39:34], byte_count[47:40]
   input  wire logic [47:0] req_tdata,
   // input_is_encrypted[0]
   input  wire logic [0:0]  req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // keystream[31:0], parity_ok[32], zero[39:33]
   output logic [39:0]      rsp_tdata,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import cr1_pkg::*;

   logic [KEY_W-1:0]  key_ff, key_in;
   dp_cmd_type        dp_cmd;
   logic [WORD_W-1:0] keystream;
   logic              parity_ok;
   logic              key_sel;

   // Key register: the only register, at byte address 0.
   assign key_sel    = (csr_paddr[3] == 1'b0);
   assign csr_pready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && key_sel) begin
         key_in = csr_pwdata[KEY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign csr_prdata = key_sel ? {16'd0, key_ff} : 64'd0;

   cr1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_cmd        (cmd_type'(req_tdata[1:0])),
      .req_bit_count  (req_tdata[39:34]),
      .req_byte_count (req_tdata[47:40]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .dp_cmd         (dp_cmd)
   );

   cr1_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .cipher_key         (key_ff),
      .data_in            (req_tdata[33:2]),
      .input_is_encrypted (req_tuser[0]),
      .keystream          (keystream),
      .parity_ok          (parity_ok)
   );

   assign rsp_tdata = {7'd0, parity_ok, keystream};

endmodule

`default_nettype wire

[rtl/cr1_dp.sv]
`default_nettype none

module cr1_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cr1_pkg::dp_cmd_type         cmd,
   input  wire logic [cr1_pkg::KEY_W-1:0]   cipher_key,
   input  wire logic [cr1_pkg::WORD_W-1:0]  data_in,
   input  wire logic                        input_is_encrypted,
   output logic      [cr1_pkg::WORD_W-1:0]  keystream,
   output logic                             parity_ok
);
   import cr1_pkg::*;

   logic [HALF_W-1:0] odd_ff, odd_in, even_ff, even_in;
   logic [HALF_W-1:0] scr_odd_ff, scr_odd_in, scr_even_ff, scr_even_in;
   logic [WORD_W-1:0] din_ff, din_in;
   logic              enc_ff, enc_in;
   logic [WORD_W-1:0] ks_ff, ks_in;
   logic              acc_ff, acc_in;
   logic              ok_ff, ok_in;
   logic [WORD_W-1:0] out_ks_ff, out_ks_in;
   logic              out_ok_ff, out_ok_in;

   logic [HALF_W-1:0] src_odd, src_even, new_odd;
   logic              step_ks, step_fb, step_bit, step_enc;

   // Shared step unit: one LFSR step on the live or the scratch register.
   always_comb begin
      src_odd  = cmd.step_scratch ? scr_odd_ff : odd_ff;
      src_even = cmd.step_scratch ? scr_even_ff : even_ff;
      step_bit = cmd.step_live & din_ff[0];
      step_enc = cmd.step_live & enc_ff;
      step_ks  = ks_filter(src_odd);
      step_fb  = (^((src_odd & TAPS_ODD) ^ (src_even & TAPS_EVEN))) ^ step_bit ^
                 (step_ks & step_enc);
      new_odd  = {src_even[HALF_W-2:0], step_fb};
   end

   // Next values of the LFSR halves.
   always_comb begin
      odd_in      = odd_ff;
      even_in     = even_ff;
      scr_odd_in  = scr_odd_ff;
      scr_even_in = scr_even_ff;
      if (cmd.load_key) begin
         odd_in  = key_odd_half(cipher_key);
         even_in = key_even_half(cipher_key);
      end else if (cmd.step_live) begin
         odd_in  = new_odd;
         even_in = odd_ff;
      end
      if (cmd.start_look) begin
         scr_odd_in  = odd_ff;
         scr_even_in = even_ff;
      end else if (cmd.step_scratch) begin
         scr_odd_in  = new_odd;
         scr_even_in = scr_odd_ff;
      end
   end

   // Request operands, keystream word and byte parity check.
   always_comb begin
      din_in = din_ff;
      enc_in = enc_ff;
      ks_in  = ks_ff;
      acc_in = acc_ff;
      ok_in  = ok_ff;
      if (cmd.capture) begin
         din_in = data_in;
         enc_in = input_is_encrypted;
         ks_in  = '0;
         acc_in = 1'b0;
         ok_in  = cmd.start_look;
      end
      if (cmd.step_live) begin
         din_in              = {1'b0, din_ff[WORD_W-1:1]};
         ks_in[cmd.bit_idx]  = step_ks;
      end
      if (cmd.step_scratch) begin
         if (cmd.check_bit) begin
            if ((acc_ff ^ 1'b1) != step_ks) begin
               ok_in = 1'b0;
            end
            acc_in = 1'b0;
         end else begin
            acc_in = acc_ff ^ step_ks;
         end
      end
   end

   // Output register.
   always_comb begin
      out_ks_in = out_ks_ff;
      out_ok_in = out_ok_ff;
      if (cmd.emit) begin
         out_ks_in = ks_ff;
         out_ok_in = ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff  <= '0;
         even_ff <= '0;
      end else begin
         odd_ff  <= odd_in;
         even_ff <= even_in;
      end
   end

   always_ff @(posedge clock) begin
      scr_odd_ff  <= scr_odd_in;
      scr_even_ff <= scr_even_in;
      din_ff      <= din_in;
      enc_ff      <= enc_in;
      ks_ff       <= ks_in;
      acc_ff      <= acc_in;
      ok_ff       <= ok_in;
      out_ks_ff   <= out_ks_in;
      out_ok_ff   <= out_ok_in;
   end

   assign keystream = out_ks_ff;
   assign parity_ok = out_ok_ff;

endmodule

`default_nettype wire

[rtl/cr1_ctrl.sv]
`default_nettype none

module cr1_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cr1_pkg::cmd_type    req_cmd,
   input  wire logic [5:0]          req_bit_count,
   input  wire logic [7:0]          req_byte_count,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output cr1_pkg::dp_cmd_type      dp_cmd
);
   import cr1_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] rem_ff, rem_in;
   logic [4:0] idx_ff, idx_in;
   logic [7:0] bytes_ff, bytes_in;
   logic [3:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic       slot_free;
   logic [5:0] bits_sat;

   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign bits_sat  = (req_bit_count > MAX_BITS) ? MAX_BITS : req_bit_count;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_CLOCK: state_in = (bits_sat == 6'd0) ? ST_DONE : ST_CLOCK;
                  CMD_LOOK:  state_in = (req_byte_count == 8'd0) ? ST_DONE : ST_LOOK;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLOCK: begin
            if (rem_ff == 6'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_LOOK: begin
            if (bytes_ff == 8'd1 && phase_ff == PARITY_PHASE) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs toward the handshake and the datapath.
   always_comb begin
      req_ready           = (state_ff == ST_IDLE);
      dp_cmd              = '0;
      dp_cmd.capture      = accept;
      dp_cmd.load_key     = accept && (req_cmd == CMD_LOAD);
      dp_cmd.start_look   = accept && (req_cmd == CMD_LOOK);
      dp_cmd.step_live    = (state_ff == ST_CLOCK);
      dp_cmd.step_scratch = (state_ff == ST_LOOK);
      dp_cmd.check_bit    = (phase_ff == PARITY_PHASE);
      dp_cmd.bit_idx      = idx_ff;
      dp_cmd.emit         = (state_ff == ST_DONE) && slot_free;
   end

   // Step counters.
   always_comb begin
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      bytes_in = bytes_ff;
      phase_in = phase_ff;
      if (accept) begin
         rem_in   = bits_sat;
         idx_in   = 5'd0;
         bytes_in = req_byte_count;
         phase_in = 4'd0;
      end else if (state_ff == ST_CLOCK) begin
         rem_in = rem_ff - 6'd1;
         idx_in = idx_ff + 5'd1;
      end else if (state_ff == ST_LOOK) begin
         if (phase_ff == PARITY_PHASE) begin
            phase_in = 4'd0;
            bytes_in = bytes_ff - 8'd1;
         end else begin
            phase_in = phase_ff + 4'd1;
         end
      end
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         idx_ff       <= '0;
         bytes_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         idx_ff       <= idx_in;
         bytes_ff     <= bytes_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // While bits are being clocked, at least one step remains.
   a_clock_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLOCK |-> rem_ff != 6'd0)
      else $error("clocking with no steps left");

   // The lookahead phase never passes the parity bit of a byte.
   a_look_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |-> phase_ff <= PARITY_PHASE && bytes_ff != 8'd0)
      else $error("lookahead counters out of range");

   // A new result only appears out of the finishing state.
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the finishing state");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted without starting work");
`endif

endmodule

`default_nettype wire
